@@ rtl/core/lobm_pkg.sv @@
`default_nettype none
package lobm_pkg;

  localparam int PRICE_W  = 12;
  localparam int QTY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_RESTED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRADE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJ_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJ_ZERO  = 2'd3;

  // Classification given to an item by the front end.
  localparam logic [KIND_W-1:0] KIND_BUY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SELL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO = 2'd2;

  typedef struct packed {
    logic              side;
    logic [PRICE_W-1:0] price_tick;
    logic [QTY_W-1:0]   quantity;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    fill_quantity;
    logic [PRICE_W-1:0]  fill_price;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } job_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/core/lobm_front.sv @@
`default_nettype none
module lobm_front
  import lobm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          job_valid,
  input  wire logic     job_ready,
  output job_t          job_data
);

  logic job_v_r;
  job_t job_r;
  logic accept;
  job_t job_nxt;

  assign in_ready  = !job_v_r || job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = job_v_r;
  assign job_data  = job_r;

  // Zero quantity is settled here; side picks the book otherwise.
  always_comb begin
    job_nxt.price = in_data.price_tick;
    job_nxt.qty   = in_data.quantity;
    if (in_data.quantity == '0) begin
      job_nxt.kind = KIND_ZERO;
    end else if (in_data.side) begin
      job_nxt.kind = KIND_SELL;
    end else begin
      job_nxt.kind = KIND_BUY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (accept) begin
      job_v_r <= 1'b1;
    end else if (job_ready) begin
      job_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lobm_queue.sv @@
`default_nettype none
module lobm_queue
  import lobm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire job_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_data
);

  job_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lobm_book.sv @@
`default_nettype none
module lobm_book
  import lobm_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data
);

  localparam int DEPTH = 1 << IDX_W;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read register holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lobm_engine.sv @@
`default_nettype none
module lobm_engine
  import lobm_pkg::*;
#(
  parameter int BOOK_SLOTS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire job_t job_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
  localparam int CNT_W = $clog2(BOOK_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BOOK_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLS  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_ICMP = 3'd3;
  localparam logic [2:0] S_MRD  = 3'd4;
  localparam logic [2:0] S_MEV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   bid_head_r, bid_head_nxt, ask_head_r, ask_head_nxt;
  logic [CNT_W-1:0]   bid_cnt_r, bid_cnt_nxt, ask_cnt_r, ask_cnt_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  job_t               cur_r, cur_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [QTY_W-1:0]   pend_qty_r, pend_qty_nxt;
  logic [PRICE_W-1:0] pend_price_r, pend_price_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               out_load;
  out_item_t          out_item;
  logic               out_free;

  logic               bid_rd_en, ask_rd_en, bid_we, ask_we;
  logic [IDX_W-1:0]   bid_ra, ask_ra, bid_wa, ask_wa;
  entry_t             bid_rd, ask_rd, bid_wd, ask_wd;

  logic               own_sell;
  logic [IDX_W-1:0]   own_head;
  logic [CNT_W-1:0]   own_cnt;
  logic [IDX_W-1:0]   slot_k, slot_km1;
  entry_t             new_entry;
  entry_t             own_rd;
  logic               worse;
  logic [QTY_W-1:0]   fill_q, bid_left, ask_left;

  lobm_book #(.IDX_W(IDX_W)) u_bid (
    .clk     (clk),
    .rd_en   (bid_rd_en),
    .rd_addr (bid_ra),
    .rd_data (bid_rd),
    .wr_en   (bid_we),
    .wr_addr (bid_wa),
    .wr_data (bid_wd)
  );

  lobm_book #(.IDX_W(IDX_W)) u_ask (
    .clk     (clk),
    .rd_en   (ask_rd_en),
    .rd_addr (ask_ra),
    .rd_data (ask_rd),
    .wr_en   (ask_we),
    .wr_addr (ask_wa),
    .wr_data (ask_wd)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign own_sell        = (cur_r.kind == KIND_SELL);
  assign own_head        = own_sell ? ask_head_r : bid_head_r;
  assign own_cnt         = own_sell ? ask_cnt_r : bid_cnt_r;
  assign slot_k          = own_head + k_r[IDX_W-1:0];
  assign slot_km1        = own_head + k_r[IDX_W-1:0] - IDX_W'(1);
  assign new_entry.price = cur_r.price;
  assign new_entry.qty   = cur_r.qty;
  assign own_rd          = own_sell ? ask_rd : bid_rd;
  // An entry that ranks behind the new order moves up one slot.
  assign worse    = own_sell ? (own_rd.price > cur_r.price) : (own_rd.price < cur_r.price);
  assign fill_q   = (bid_rd.qty < ask_rd.qty) ? bid_rd.qty : ask_rd.qty;
  assign bid_left = bid_rd.qty - fill_q;
  assign ask_left = ask_rd.qty - fill_q;

  always_comb begin
    state_nxt      = state_r;
    bid_head_nxt   = bid_head_r;
    ask_head_nxt   = ask_head_r;
    bid_cnt_nxt    = bid_cnt_r;
    ask_cnt_nxt    = ask_cnt_r;
    k_nxt          = k_r;
    cur_nxt        = cur_r;
    pend_v_nxt     = pend_v_r;
    pend_qty_nxt   = pend_qty_r;
    pend_price_nxt = pend_price_r;
    job_ready      = 1'b0;
    out_load       = 1'b0;
    out_item       = '0;
    bid_rd_en      = 1'b0;
    ask_rd_en      = 1'b0;
    bid_ra         = bid_head_r;
    ask_ra         = ask_head_r;
    bid_we         = 1'b0;
    ask_we         = 1'b0;
    bid_wa         = slot_k;
    ask_wa         = slot_k;
    bid_wd         = new_entry;
    ask_wd         = new_entry;

    unique case (state_r)
      S_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          cur_nxt   = job_data;
          state_nxt = S_CLS;
        end
      end
      S_CLS: begin
        if (cur_r.kind == KIND_ZERO) begin
          if (out_free) begin
            out_load        = 1'b1;
            out_item.status = ST_REJ_ZERO;
            out_item.last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (own_cnt >= FULL_CNT) begin
          if (out_free) begin
            out_load        = 1'b1;
            out_item.status = ST_REJ_FULL;
            out_item.last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          k_nxt     = own_cnt;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (k_r == '0) begin
          if (own_sell) begin
            ask_we      = 1'b1;
            ask_cnt_nxt = ask_cnt_r + CNT_W'(1);
          end else begin
            bid_we      = 1'b1;
            bid_cnt_nxt = bid_cnt_r + CNT_W'(1);
          end
          state_nxt = S_MRD;
        end else begin
          if (own_sell) begin
            ask_rd_en = 1'b1;
            ask_ra    = slot_km1;
          end else begin
            bid_rd_en = 1'b1;
            bid_ra    = slot_km1;
          end
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        if (worse) begin
          bid_wd    = own_rd;
          ask_wd    = own_rd;
          k_nxt     = k_r - CNT_W'(1);
          state_nxt = S_INS;
        end else begin
          if (own_sell) begin
            ask_cnt_nxt = ask_cnt_r + CNT_W'(1);
          end else begin
            bid_cnt_nxt = bid_cnt_r + CNT_W'(1);
          end
          state_nxt = S_MRD;
        end
        bid_we = !own_sell;
        ask_we = own_sell;
      end
      S_MRD: begin
        if (bid_cnt_r == '0 || ask_cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          bid_rd_en = 1'b1;
          ask_rd_en = 1'b1;
          state_nxt = S_MEV;
        end
      end
      S_MEV: begin
        if (bid_rd.price >= ask_rd.price) begin
          if (!pend_v_r || out_free) begin
            // The previous fill goes out now; this one waits to learn if it is last.
            if (pend_v_r) begin
              out_load               = 1'b1;
              out_item.status        = ST_TRADE;
              out_item.fill_quantity = pend_qty_r;
              out_item.fill_price    = pend_price_r;
            end
            pend_v_nxt     = 1'b1;
            pend_qty_nxt   = fill_q;
            pend_price_nxt = ask_rd.price;
            if (bid_left == '0) begin
              bid_head_nxt = bid_head_r + IDX_W'(1);
              bid_cnt_nxt  = bid_cnt_r - CNT_W'(1);
            end else begin
              bid_we     = 1'b1;
              bid_wa     = bid_head_r;
              bid_wd     = bid_rd;
              bid_wd.qty = bid_left;
            end
            if (ask_left == '0) begin
              ask_head_nxt = ask_head_r + IDX_W'(1);
              ask_cnt_nxt  = ask_cnt_r - CNT_W'(1);
            end else begin
              ask_we     = 1'b1;
              ask_wa     = ask_head_r;
              ask_wd     = ask_rd;
              ask_wd.qty = ask_left;
            end
            state_nxt = S_MRD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_item.last = 1'b1;
          if (pend_v_r) begin
            out_item.status        = ST_TRADE;
            out_item.fill_quantity = pend_qty_r;
            out_item.fill_price    = pend_price_r;
          end else begin
            out_item.status = ST_RESTED;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bid_head_r  <= '0;
      ask_head_r  <= '0;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bid_head_r <= bid_head_nxt;
      ask_head_r <= ask_head_nxt;
      bid_cnt_r  <= bid_cnt_nxt;
      ask_cnt_r  <= ask_cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    cur_r        <= cur_nxt;
    pend_qty_r   <= pend_qty_nxt;
    pend_price_r <= pend_price_nxt;
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bid_cnt_r <= FULL_CNT) && (ask_cnt_r <= FULL_CNT))
    else $error("book count above capacity");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("fill left pending between items");

  a_eval_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEV) |-> (bid_cnt_r != '0) && (ask_cnt_r != '0))
    else $error("match evaluated on an empty book");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten while held");

endmodule
`default_nettype wire

@@ rtl/core/limit_order_book_matcher_top.sv @@
`default_nettype none
// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_ready
// out_      output     out_item_t  out_valid / out_ready
//
// An item passes through the front register and the queue. The engine then
// classifies it, moves aside each resting order that ranks behind it when
// inserting, places the order, takes each fill in turn and finishes; a rejected
// item is answered at classification. Each visited book entry takes a read
// state and an evaluate state, since each book memory has a single read port
// whose read data is registered.
// Reset clears the queue, the book counts and heads; book contents are not cleared.
// A stalled result channel holds the engine; the queue keeps accepting up to two
// items meanwhile, so the input side only stalls when the queue and front are full.
module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int BOOK_SLOTS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic f_valid, f_ready;
  job_t f_job;
  logic q_valid, q_ready;
  job_t q_job;

  // The front registers each item and marks zero quantity orders as rejects.
  lobm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_data  (f_job)
  );

  // A two entry queue decouples the front from the book engine.
  lobm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_job)
  );

  // The engine inserts into the sorted books and walks the crossing fronts.
  lobm_engine #(.BOOK_SLOTS(BOOK_SLOTS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_data  (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ bench/limit_order_book_matcher_top_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher_top_tb;
  import lobm_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  limit_order_book_matcher_top #(.BOOK_SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // The predicted books, each kept sorted best price first and by arrival within a price.
  entry_t bid_book[$];
  entry_t ask_book[$];
  // Fills and acknowledgements that the block still owes us, oldest first.
  out_item_t pending_fills[$];

  int error_count = 0;
  int cycle_count = 0;
  // When set, the result side never stalls and the sender never pauses.
  bit steady = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Rest an order in its book behind every order of equal or better price.
  function automatic void rest_order(bit is_sell, entry_t e);
    int pos;
    pos = 0;
    if (is_sell) begin
      while (pos < ask_book.size() && ask_book[pos].price <= e.price) pos++;
      ask_book.insert(pos, e);
    end else begin
      while (pos < bid_book.size() && bid_book[pos].price >= e.price) pos++;
      bid_book.insert(pos, e);
    end
  endfunction

  function automatic out_item_t make_result(logic [STATUS_W-1:0] st, logic [QTY_W-1:0] q,
                                            logic [PRICE_W-1:0] p, logic lst);
    out_item_t r;
    r.status = st;
    r.fill_quantity = q;
    r.fill_price = p;
    r.last = lst;
    return r;
  endfunction

  // Appends one expected result behind those already owed.
  function automatic void owe_result(out_item_t r);
    pending_fills.insert(pending_fills.size(), r);
  endfunction

  // Work out the results an accepted order causes and update the books.
  function automatic void match_order(in_item_t o);
    entry_t e;
    logic [QTY_W-1:0] traded;
    int fills;
    fills = 0;
    if (o.quantity == 0) begin
      owe_result(make_result(ST_REJ_ZERO, 0, 0, 1'b1));
      return;
    end
    if ((o.side ? ask_book.size() : bid_book.size()) >= SLOTS) begin
      owe_result(make_result(ST_REJ_FULL, 0, 0, 1'b1));
      return;
    end
    e.price = o.price_tick;
    e.qty = o.quantity;
    rest_order(o.side, e);
    while (fills < 64 && bid_book.size() > 0 && ask_book.size() > 0 &&
           bid_book[0].price >= ask_book[0].price) begin
      traded = (bid_book[0].qty < ask_book[0].qty) ? bid_book[0].qty : ask_book[0].qty;
      owe_result(make_result(ST_TRADE, traded, ask_book[0].price, 1'b0));
      fills++;
      bid_book[0].qty -= traded;
      ask_book[0].qty -= traded;
      if (bid_book[0].qty == 0) void'(bid_book.pop_front());
      if (ask_book[0].qty == 0) void'(ask_book.pop_front());
    end
    if (fills == 0) owe_result(make_result(ST_RESTED, 0, 0, 1'b1));
    else pending_fills[pending_fills.size() - 1].last = 1'b1;
  endfunction

  // Result checker: compares every accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fills.size() == 0) begin
        $error("unexpected result: status=%0d qty=%0d price=%0d last=%0d",
               out_data.status, out_data.fill_quantity, out_data.fill_price,
               out_data.last);
        error_count++;
      end else begin
        want = pending_fills.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.fill_quantity !== want.fill_quantity) begin
          $error("fill_quantity: expected %0d, got %0d", want.fill_quantity,
                 out_data.fill_quantity);
          error_count++;
        end
        if (out_data.fill_price !== want.fill_price) begin
          $error("fill_price: expected %0d, got %0d", want.fill_price, out_data.fill_price);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  // The result side stalls in random bursts.
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sends one order; the prediction is made at the accepting edge. Valid stays
  // high into the next call unless the sender idles afterwards.
  task automatic send_order(bit is_sell, logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
    in_item_t o;
    int gap;
    o.side = is_sell;
    o.price_tick = price;
    o.quantity = qty;
    in_valid <= 1'b1;
    in_data <= o;
    do @(posedge clk); while (!in_ready);
    match_order(o);
    @(negedge clk);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // Field extremes, zero quantity, a plain rest and a sweep across several levels.
  task automatic test_directed();
    send_order(0, 0, 0);
    send_order(1, 12'hFFF, 0);
    send_order(0, 12'd100, 16'hFFFF);
    send_order(0, 12'd100, 16'd5);
    send_order(0, 12'd90, 16'd7);
    send_order(1, 12'd110, 16'd3);
    send_order(1, 12'd110, 16'd4);
    send_order(1, 12'd80, 16'd1);
    send_order(1, 12'd0, 16'hFFFF);
    send_order(0, 12'hFFF, 16'hFFFF);
    send_order(0, 12'hFFF, 16'd1);
    send_order(1, 12'h555, 16'h5555);
    send_order(0, 12'hAAA, 16'hAAAA);
  endtask

  // Fill the bid book, then the ask book, to capacity and get full rejections on each.
  task automatic test_book_full();
    wait_drained();
    while (bid_book.size() < SLOTS)
      send_order(0, 12'($urandom_range(1, 40)), 16'($urandom_range(1, 50)));
    send_order(0, 12'd30, 16'd9);
    send_order(0, 12'hFFF, 16'd9);
    while (ask_book.size() < SLOTS)
      send_order(1, 12'($urandom_range(100, 4095)), 16'($urandom_range(1, 50)));
    send_order(1, 12'd200, 16'd1);
    // This sell is rejected because the ask book is full.
    send_order(1, 12'd0, 16'hFFFF);
    send_order(0, 12'hFFF, 16'hFFFF);
  endtask

  // Orders clustered around a mid price so that most of them trade.
  task automatic test_random_flow(int count);
    int mid;
    logic [QTY_W-1:0] q;
    for (int i = 0; i < count; i++) begin
      mid = 2048;
      case ($urandom_range(0, 9))
        0: q = 0;
        1: q = 16'($urandom);
        default: q = 16'($urandom_range(1, 300));
      endcase
      if ($urandom_range(0, 7) == 0)
        send_order(1'($urandom), 12'($urandom), q);
      else
        send_order(1'($urandom), 12'($urandom_range(mid - 20, mid + 20)), q);
      // The sender once holds off until everything owed has arrived.
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_book_full();
    test_random_flow(12);
    // The last stretch runs with no idling on either side.
    steady = 1;
    test_random_flow(8);
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_fills.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/lobm_pkg.sv
rtl/core/lobm_front.sv
rtl/core/lobm_queue.sv
rtl/core/lobm_book.sv
rtl/core/lobm_engine.sv
rtl/core/limit_order_book_matcher_top.sv
bench/limit_order_book_matcher_top_tb.sv
